// File: design/imq_pkg.sv
// Package for the indexed min priority queue: operation and status codes,
// and the sequencer state type. No dependencies.
package imq_pkg;

   localparam int ID_BITS = 6;
   localparam int ID_SPACE = 64;

   typedef enum logic [1:0] {
      KIND_INSERT   = 2'd0,
      KIND_EXTRACT  = 2'd1,
      KIND_PEEK     = 2'd2,
      KIND_DECREASE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAP_RD,
      S_DEC_RD,
      S_DEC_CHK,
      S_ROOT_RD,
      S_ROOT_CHK,
      S_LAST_RD,
      S_LAST_WR,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_RD2,
      S_DN_CMP,
      S_CLEAR,
      S_DONE
   } state_type;

endpackage

// File: design/imq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module imq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

// File: design/indexed_min_priority_queue_unit.sv
// Top level of the indexed min priority queue: sequencer over heap and map RAMs.
// Depends on imq_pkg and imq_ram.
//
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | req_kind, req_id, req_priority_req
// rsp     | out       | rsp_valid/rsp_ready | rsp_status, rsp_out_priority, rsp_out_id
//
// Insert and decrease sift the entry up one level per step, extract sifts the last
// entry down from the root, peek reads the root; all share the single heap RAM port.
// After reset a clearing pass over all 64 map entries empties the position map before any request.
// One transaction is at work at a time; the result register holds until rsp_ready.
module indexed_min_priority_queue_unit #(
   parameter int CAPACITY = 64,
   parameter int PRIORITY_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [5:0]               req_id,
   input  logic [PRIORITY_BITS-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [PRIORITY_BITS-1:0] rsp_out_priority,
   output logic [5:0]               rsp_out_id
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int HW = PRIORITY_BITS + imq_pkg::ID_BITS;
   localparam int MW = AW + 1;
   localparam int XW = AW + 2;

   imq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in, oth_ff, oth_in;
   logic [HW-1:0] cur_ff, cur_in, l_ff, l_in;
   logic [1:0]    kind_ff, kind_in;
   logic [5:0]    id_ff, id_in, clr_ff, clr_in;
   logic [PRIORITY_BITS-1:0] pr_ff, pr_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rs_ff, rs_in;
   logic [PRIORITY_BITS-1:0] rp_ff, rp_in;
   logic [5:0]    ri_ff, ri_in;

   logic          h_we, m_we;
   logic [AW-1:0] h_addr;
   logic [HW-1:0] h_wd, h_rd;
   logic [5:0]    m_addr;
   logic [MW-1:0] m_wd, m_rd;

   imq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
      .clock(clock), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
   imq_ram #(.WIDTH(MW), .DEPTH(imq_pkg::ID_SPACE)) u_map (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

   function automatic logic [PRIORITY_BITS-1:0] pri(input logic [HW-1:0] e);
      pri = e[HW-1:imq_pkg::ID_BITS];
   endfunction

   logic [XW-1:0] lc, rc;
   logic [PRIORITY_BITS-1:0] best_p;
   logic          take_r;

   always_comb begin
      lc = XW'({pos_ff, 1'b1});
      rc = lc + XW'(1);
      take_r = (rc < XW'(count_ff)) && (pri(h_rd) < pri(cur_ff));
      best_p = take_r ? pri(h_rd) : pri(cur_ff);
   end

   assign req_ready = (state_ff == imq_pkg::S_IDLE) && !rv_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff; pos_in = pos_ff; oth_in = oth_ff;
      cur_in = cur_ff; l_in = l_ff;
      kind_in = kind_ff; id_in = id_ff; pr_in = pr_ff; clr_in = clr_ff;
      rv_in = rv_ff; rs_in = rs_ff; rp_in = rp_ff; ri_in = ri_ff;
      h_we = 1'b0; h_addr = pos_ff; h_wd = cur_ff;
      m_we = 1'b0; m_addr = id_ff; m_wd = {1'b1, pos_ff};
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         imq_pkg::S_CLEAR: begin
            m_we = 1'b1; m_addr = clr_ff; m_wd = '0;
            clr_in = clr_ff + 6'd1;
            if (clr_ff == 6'd63) state_in = imq_pkg::S_IDLE;
         end
         imq_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               kind_in = req_kind; id_in = req_id;
               pr_in = req_priority_req;
               m_addr = req_id;
               rs_in = imq_pkg::ST_OK; rp_in = '0; ri_in = '0;
               unique case (imq_pkg::kind_type'(req_kind))
                  imq_pkg::KIND_INSERT, imq_pkg::KIND_DECREASE:
                     state_in = imq_pkg::S_MAP_RD;
                  default: begin
                     if (count_ff == '0) begin
                        rs_in = imq_pkg::ST_EMPTY; state_in = imq_pkg::S_DONE;
                     end else begin
                        pos_in = '0; state_in = imq_pkg::S_ROOT_RD;
                     end
                  end
               endcase
            end
         end
         imq_pkg::S_MAP_RD: begin
            if (kind_ff == imq_pkg::KIND_INSERT) begin
               if (m_rd[AW] || count_ff >= CW'(CAPACITY)) begin
                  rs_in = imq_pkg::ST_FULL; state_in = imq_pkg::S_DONE;
               end else begin
                  pos_in = count_ff[AW-1:0];
                  cur_in = {pr_ff, id_ff};
                  count_in = count_ff + CW'(1);
                  state_in = imq_pkg::S_UP_RD;
               end
            end else begin
               if (!m_rd[AW] || CW'(m_rd[AW-1:0]) >= count_ff) begin
                  rs_in = imq_pkg::ST_ABSENT; state_in = imq_pkg::S_DONE;
               end else begin
                  pos_in = m_rd[AW-1:0]; state_in = imq_pkg::S_DEC_RD;
               end
            end
         end
         imq_pkg::S_DEC_RD: begin
            h_addr = pos_ff; state_in = imq_pkg::S_DEC_CHK;
         end
         imq_pkg::S_DEC_CHK: begin
            if (pri(h_rd) <= pr_ff) begin
               rs_in = imq_pkg::ST_ABSENT; state_in = imq_pkg::S_DONE;
            end else begin
               cur_in = {pr_ff, id_ff}; state_in = imq_pkg::S_UP_RD;
            end
         end
         imq_pkg::S_UP_RD: begin
            // Read parent, or finish by writing the entry where it rests.
            if (pos_ff == '0) begin
               h_we = 1'b1; h_addr = pos_ff; h_wd = cur_ff;
               m_we = 1'b1; m_addr = cur_ff[5:0]; m_wd = {1'b1, pos_ff};
               state_in = imq_pkg::S_DONE;
            end else begin
               oth_in = (pos_ff - AW'(1)) >> 1;
               h_addr = (pos_ff - AW'(1)) >> 1;
               state_in = imq_pkg::S_UP_CMP;
            end
         end
         imq_pkg::S_UP_CMP: begin
            if (pri(h_rd) > pri(cur_ff)) begin
               h_we = 1'b1; h_addr = pos_ff; h_wd = h_rd;
               m_we = 1'b1; m_addr = h_rd[5:0]; m_wd = {1'b1, pos_ff};
               pos_in = oth_ff;
            end else begin
               h_we = 1'b1; h_addr = pos_ff; h_wd = cur_ff;
               m_we = 1'b1; m_addr = cur_ff[5:0]; m_wd = {1'b1, pos_ff};
               state_in = imq_pkg::S_DONE;
            end
            if (pri(h_rd) > pri(cur_ff)) state_in = imq_pkg::S_UP_RD;
         end
         imq_pkg::S_ROOT_RD: begin
            h_addr = '0; state_in = imq_pkg::S_ROOT_CHK;
         end
         imq_pkg::S_ROOT_CHK: begin
            rp_in = pri(h_rd); ri_in = h_rd[5:0];
            if (kind_ff == imq_pkg::KIND_PEEK) begin
               state_in = imq_pkg::S_DONE;
            end else begin
               m_we = 1'b1; m_addr = h_rd[5:0]; m_wd = '0;
               count_in = count_ff - CW'(1);
               state_in = (count_ff == CW'(1)) ? imq_pkg::S_DONE : imq_pkg::S_LAST_RD;
            end
         end
         imq_pkg::S_LAST_RD: begin
            h_addr = count_ff[AW-1:0]; state_in = imq_pkg::S_LAST_WR;
         end
         imq_pkg::S_LAST_WR: begin
            cur_in = h_rd; pos_in = '0; state_in = imq_pkg::S_DN_RD;
         end
         imq_pkg::S_DN_RD: begin
            if (lc >= XW'(count_ff)) begin
               h_we = 1'b1; h_addr = pos_ff; h_wd = cur_ff;
               m_we = 1'b1; m_addr = cur_ff[5:0]; m_wd = {1'b1, pos_ff};
               state_in = imq_pkg::S_DONE;
            end else begin
               h_addr = lc[AW-1:0]; state_in = imq_pkg::S_DN_RD2;
            end
         end
         imq_pkg::S_DN_RD2: begin
            l_in = h_rd;
            h_addr = (rc < XW'(count_ff)) ? rc[AW-1:0] : lc[AW-1:0];
            state_in = imq_pkg::S_DN_CMP;
         end
         imq_pkg::S_DN_CMP: begin
            if (pri(l_ff) < best_p || take_r) begin
               h_we = 1'b1; h_addr = pos_ff;
               h_wd = (pri(l_ff) < best_p) ? l_ff : h_rd;
               m_we = 1'b1; m_addr = h_wd[5:0]; m_wd = {1'b1, pos_ff};
               pos_in = (pri(l_ff) < best_p) ? lc[AW-1:0] : rc[AW-1:0];
               state_in = imq_pkg::S_DN_RD;
            end else begin
               h_we = 1'b1; h_addr = pos_ff; h_wd = cur_ff;
               m_we = 1'b1; m_addr = cur_ff[5:0]; m_wd = {1'b1, pos_ff};
               state_in = imq_pkg::S_DONE;
            end
         end
         imq_pkg::S_DONE: begin
            rv_in = 1'b1; state_in = imq_pkg::S_IDLE;
         end
         default: state_in = imq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imq_pkg::S_CLEAR;
         count_ff <= '0;
         clr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
      pos_ff <= pos_in; oth_ff <= oth_in; cur_ff <= cur_in;
      l_ff <= l_in;
      kind_ff <= kind_in; id_ff <= id_in; pr_ff <= pr_in;
      rs_ff <= rs_in; rp_ff <= rp_in; ri_ff <= ri_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_out_priority = rp_ff;
   assign rsp_out_id = ri_ff;

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count beyond capacity");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == imq_pkg::S_IDLE) else $error("work while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(rs_ff)) else $error("result dropped");
endmodule
